// ===== src/mwpt_pkg.sv =====
// shared types and constants of the multi-wheel period tachometer
// no dependencies
`timescale 1ns / 1ps
package mwpt_pkg;
  localparam int unsigned NumChannels = 4;
  localparam int unsigned WheelW = 2;
  localparam int unsigned QDepth = 2;

  localparam logic [26:0] TickRateRst = 27'd1000000;
  localparam logic [13:0] CircRst = 14'd2000;
  localparam logic [10:0] PprRst = 11'd20;
  localparam logic [31:0] StaleRst = 32'd500000;

  localparam logic [1:0] RegTickRate = 2'd0;
  localparam logic [1:0] RegCirc = 2'd1;
  localparam logic [1:0] RegPpr = 2'd2;
  localparam logic [1:0] RegStale = 2'd3;

  typedef enum logic {
    KIND_PULSE = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_e;

  // queue entry between front and back
  typedef struct packed {
    logic [WheelW-1:0] wheel_id;
    logic [31:0] period;
    logic stale;
    logic last;
  } job_t;

  typedef struct packed {
    logic [WheelW-1:0] wheel_id;
    logic [31:0] period;
    logic [31:0] freq;
    logic [31:0] speed;
    logic [31:0] rpm;
    logic stale;
    logic last;
  } res_t;
endpackage

// ===== src/multi_wheel_period_tachometer_top.sv =====
// top level of the multi-wheel period tachometer: config registers,
// front, job queue, back; depends on mwpt_pkg and all mwpt_* modules
`timescale 1ns / 1ps
// a pulse transaction updates that wheel's interval and last time; an
// update transaction fans out to four wheel results. each wheel costs a
// multiply plus three 43-step passes of one shared restoring divider; a
// stale or zero-period wheel skips the divider. rates saturate at 32 bits
// and read zero for stale wheels.
module multi_wheel_period_tachometer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [1:0]  wheel_i,
  input  logic [31:0] timestamp_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  wheel_id_o,
  output logic [31:0] period_ticks_o,
  output logic [31:0] freq_millihz_o,
  output logic [31:0] speed_mm_per_s_o,
  output logic [31:0] rpm_milli_o,
  output logic        stale_o,
  output logic        last_o
);
  logic [26:0] tick_rate_q;
  logic [13:0] circ_q;
  logic [10:0] ppr_q;
  logic [31:0] stale_limit_q;
  logic fj_valid, fj_stall, bj_valid, bj_stall;
  mwpt_pkg::job_t fj, bj;
  mwpt_pkg::res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= mwpt_pkg::TickRateRst;
      circ_q <= mwpt_pkg::CircRst;
      ppr_q <= mwpt_pkg::PprRst;
      stale_limit_q <= mwpt_pkg::StaleRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mwpt_pkg::RegTickRate: tick_rate_q <= cfg_data_i[26:0];
        mwpt_pkg::RegCirc: circ_q <= cfg_data_i[13:0];
        mwpt_pkg::RegPpr: ppr_q <= cfg_data_i[10:0];
        mwpt_pkg::RegStale: stale_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mwpt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .kind_i, .wheel_i, .timestamp_i,
    .stale_limit_i(stale_limit_q),
    .job_valid_o(fj_valid), .job_stall_i(fj_stall), .job_o(fj)
  );

  mwpt_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fj_valid), .in_stall_o(fj_stall), .in_job_i(fj),
    .out_valid_o(bj_valid), .out_stall_i(bj_stall), .out_job_o(bj)
  );

  mwpt_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_stall_o(bj_stall), .job_i(bj),
    .tick_rate_i(tick_rate_q), .circ_i(circ_q), .ppr_i(ppr_q),
    .res_valid_o(out_valid_o), .res_stall_i(out_stall_i), .res_o(res)
  );

  assign wheel_id_o = res.wheel_id;
  assign period_ticks_o = res.period;
  assign freq_millihz_o = res.freq;
  assign speed_mm_per_s_o = res.speed;
  assign rpm_milli_o = res.rpm;
  assign stale_o = res.stale;
  assign last_o = res.last;
endmodule

// ===== src/mwpt_front.sv =====
// front part: pulse bookkeeping, update expansion into one job per wheel
// depends on mwpt_pkg
`timescale 1ns / 1ps
module mwpt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [1:0]          wheel_i,
  input  logic [31:0]         timestamp_i,
  input  logic [31:0]         stale_limit_i,
  output logic                job_valid_o,
  input  logic                job_stall_i,
  output mwpt_pkg::job_t      job_o
);
  logic [31:0] last_q [mwpt_pkg::NumChannels];
  logic [31:0] last_d [mwpt_pkg::NumChannels];
  logic [31:0] per_q  [mwpt_pkg::NumChannels];
  logic [31:0] per_d  [mwpt_pkg::NumChannels];
  logic        busy_q, busy_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] now_q, now_d;
  logic [31:0] gap;

  assign in_stall_o = busy_q;
  assign gap = now_q - last_q[idx_q];
  assign job_valid_o = busy_q;
  assign job_o.wheel_id = idx_q;
  assign job_o.period = per_q[idx_q];
  assign job_o.stale = gap > stale_limit_i;
  assign job_o.last = (idx_q == 2'(mwpt_pkg::NumChannels - 1));

  always_comb begin
    busy_d = busy_q;
    idx_d = idx_q;
    now_d = now_q;
    last_d = last_q;
    per_d = per_q;
    if (busy_q && !job_stall_i) begin
      if (job_o.last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (in_valid_i && !busy_q) begin
      if (kind_i == mwpt_pkg::KIND_UPDATE) begin
        busy_d = 1'b1;
        idx_d = '0;
        now_d = timestamp_i;
      end else begin
        per_d[wheel_i] = timestamp_i - last_q[wheel_i];
        last_d[wheel_i] = timestamp_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q <= '0;
      now_q <= '0;
      for (int i = 0; i < mwpt_pkg::NumChannels; i++) begin
        last_q[i] <= '0;
        per_q[i] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      idx_q <= idx_d;
      now_q <= now_d;
      last_q <= last_d;
      per_q <= per_d;
    end
  end
endmodule

// ===== src/mwpt_queue.sv =====
// two-entry job queue between front and back
// depends on mwpt_pkg
`timescale 1ns / 1ps
module mwpt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mwpt_pkg::job_t in_job_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mwpt_pkg::job_t out_job_o
);
  mwpt_pkg::job_t mem_q [mwpt_pkg::QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_stall_o = (cnt_q == 2'(mwpt_pkg::QDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_job_o = mem_q[rp_q];
  assign push = in_valid_i && !in_stall_o;
  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== src/mwpt_back.sv =====
// back part: multiplies numerators and denominator, runs a shared restoring
// divider three times per non-stale, nonzero-period wheel, holds the result
// depends on mwpt_pkg
`timescale 1ns / 1ps
module mwpt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_stall_o,
  input  mwpt_pkg::job_t job_i,
  input  logic [26:0]    tick_rate_i,
  input  logic [13:0]    circ_i,
  input  logic [10:0]    ppr_i,
  output logic           res_valid_o,
  input  logic           res_stall_i,
  output mwpt_pkg::res_t res_o
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  mwpt_pkg::job_t job_q;
  logic [42:0] den_q;        // period * ppr
  logic [42:0] num_f_q;      // 1000 * rate
  logic [40:0] num_s_q;      // rate * circ
  logic [42:0] num_r_q;      // 60000 * rate
  logic [1:0]  sel_q;        // which quotient
  logic [5:0]  bit_q;
  logic [42:0] rem_q;
  logic [42:0] num_q;
  logic [42:0] quo_q;
  logic [42:0] quo_nx;
  logic [42:0] divisor;
  logic [43:0] trial;
  logic [31:0] sat;
  logic        zero_q;
  logic [31:0] fr_q, sp_q, rp_q;

  assign job_stall_o = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);
  assign res_o.wheel_id = job_q.wheel_id;
  assign res_o.period = job_q.period;
  assign res_o.freq = fr_q;
  assign res_o.speed = sp_q;
  assign res_o.rpm = rp_q;
  assign res_o.stale = job_q.stale;
  assign res_o.last = job_q.last;

  assign divisor = (sel_q == 2'd0) ? {11'd0, job_q.period} : den_q;
  assign trial = {rem_q, num_q[42]} - {1'b0, divisor};
  assign quo_nx = {quo_q[41:0], ~trial[43]};
  assign sat = (quo_nx[42:32] != '0) ? 32'hFFFF_FFFF : quo_nx[31:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (job_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = zero_q ? ST_OUT : ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (bit_q == '0 && sel_q == 2'd2) state_d = ST_OUT;
        else if (bit_q == '0) state_d = ST_LOAD;
      end
      ST_OUT:  if (!res_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        job_q <= job_i;
        zero_q <= job_i.stale || (job_i.period == '0);
        sel_q <= 2'd0;
        fr_q <= '0;
        sp_q <= '0;
        rp_q <= '0;
      end
      ST_MUL: begin
        den_q <= 43'(job_q.period) * 43'(ppr_i);
        num_f_q <= 43'(tick_rate_i) * 43'd1000;
        num_s_q <= 41'(tick_rate_i) * 41'(circ_i);
        num_r_q <= 43'(tick_rate_i) * 43'd60000;
      end
      ST_LOAD: begin
        rem_q <= '0;
        quo_q <= '0;
        bit_q <= 6'd42;
        case (sel_q)
          2'd0: num_q <= num_f_q;
          2'd1: num_q <= {2'b0, num_s_q};
          default: num_q <= num_r_q;
        endcase
      end
      ST_DIV: begin
        num_q <= {num_q[41:0], 1'b0};
        if (!trial[43]) begin
          rem_q <= trial[42:0];
        end else begin
          rem_q <= {rem_q[41:0], num_q[42]};
        end
        quo_q <= quo_nx;
        bit_q <= bit_q - 6'd1;
        // last step: the finished quotient goes straight to its result
        if (bit_q == '0) begin
          sel_q <= sel_q + 2'd1;
          case (sel_q)
            2'd0: fr_q <= sat;
            2'd1: sp_q <= (den_q == '0) ? '0 : sat;
            default: rp_q <= (den_q == '0) ? '0 : sat;
          endcase
        end
      end
      default: begin
      end
    endcase
  end
endmodule
